FILE: rtl/core/counting_semaphore_fifo_assert.svh
// Assertion macros shared by the counting semaphore RTL.
`ifndef COUNTING_SEMAPHORE_FIFO_ASSERT_SVH
`define COUNTING_SEMAPHORE_FIFO_ASSERT_SVH

// Checked at every rising clock edge, disabled while reset is asserted.
`define CSF_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every rising clock edge, including during reset.
`define CSF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/core/csf_pkg.sv
// Shared types, widths and codes for the counting semaphore with wait queue.
`default_nettype none

package csf_pkg;

  // Field widths of the stream items.
  localparam int TID_W       = 16;
  localparam int COUNT_W     = 16;
  localparam int WAITING_W   = 5;
  localparam int STATUS_W    = 3;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 40;

  // Widest thread id the queue can hold.
  localparam int ID_MAX_BITS = 32;

  // Default sizes.
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_BITS_DEF     = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  // Operation codes.
  localparam logic OP_WAIT   = 1'b0;
  localparam logic OP_SIGNAL = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_GRANTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BLOCKED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_WOKEN    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_INCR     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd4;

endpackage

`default_nettype wire

FILE: rtl/core/counting_semaphore_fifo.sv
// Counting semaphore with a first-in first-out wait queue held in a memory.
//
// Each item passes two steps when the result side is ready: at the accepting
// edge the queue memory is read at the head slot, and in the S_EXEC state
// the count, the head, tail and fill pointers and the memory are updated and
// the result is loaded into the output register. The registered read of the
// queue memory makes this split necessary. A new item is accepted while a result
// still waits in the output register; the update cycle stalls only while that
// register is full and not taken. Writing cfg_wdata loads the count and
// empties the queue; the queue memory itself is never cleared.
`default_nettype none

module counting_semaphore_fifo #(
  parameter int QUEUE_DEPTH = csf_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = csf_pkg::ID_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // Configuration: initial_count.
  input  wire logic                             cfg_we,
  input  wire logic [csf_pkg::COUNT_W-1:0]      cfg_wdata,
  // Request channel.
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [csf_pkg::IN_TDATA_W-1:0]   in_tdata,   // [15:0] thread_id
  input  wire logic                             in_tuser,   // [0] op
  // Result channel.
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [15:0] woken_thread, [31:16] current_count, [36:32] waiting, [39:37] zero
  output logic [csf_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output logic [csf_pkg::STATUS_W-1:0]          out_tuser   // [2:0] status
);

  import csf_pkg::*;

  localparam int IDX_W      = $clog2(QUEUE_DEPTH);
  localparam int FILL_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int FILL_EXT_W = (FILL_W > WAITING_W) ? FILL_W : WAITING_W;

  localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(QUEUE_DEPTH);

  // Sequencer states.
  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                  state_r, state_nxt;
  logic                  op_r;
  logic [TID_W-1:0]      tid_r;
  logic [COUNT_W-1:0]    count_r, count_nxt;
  logic [IDX_W-1:0]      head_r, head_nxt;
  logic [IDX_W-1:0]      tail_r, tail_nxt;
  logic [FILL_W-1:0]     fill_r, fill_nxt;

  logic [ID_BITS-1:0]    queue_mem [QUEUE_DEPTH];
  logic [ID_BITS-1:0]    rd_data_r;
  logic                  mem_we;
  logic [ID_BITS-1:0]    mem_wdata;

  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r, status_nxt;
  logic [TID_W-1:0]      out_woken_r, woken_nxt;
  logic [COUNT_W-1:0]    out_count_r;
  logic [WAITING_W-1:0]  out_waiting_r, waiting_nxt;

  logic                  in_accept;
  logic                  exec_go;
  logic [ID_MAX_BITS-1:0] tid_ext;
  logic [ID_MAX_BITS-1:0] rd_ext;
  logic [FILL_EXT_W-1:0]  fill_ext;

  assign in_tready  = (state_r == S_IDLE);
  assign in_accept  = in_tvalid && in_tready;
  assign exec_go    = (state_r == S_EXEC) && (!out_valid_r || out_tready);

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {3'b000, out_waiting_r, out_count_r, out_woken_r};

  // Width adaption of the thread id into and out of the queue.
  always_comb begin
    tid_ext              = '0;
    tid_ext[TID_W-1:0]   = tid_r;
    mem_wdata            = tid_ext[ID_BITS-1:0];
    rd_ext               = '0;
    rd_ext[ID_BITS-1:0]  = rd_data_r;
  end

  // Count and queue update for the held item.
  always_comb begin
    count_nxt  = count_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    fill_nxt   = fill_r;
    mem_we     = 1'b0;
    woken_nxt  = '0;
    status_nxt = ST_OVERFLOW;
    if (op_r == OP_WAIT) begin
      if (count_r != '0) begin
        count_nxt  = count_r - 1'b1;
        status_nxt = ST_GRANTED;
      end else if (fill_r == FILL_FULL) begin
        status_nxt = ST_OVERFLOW;
      end else begin
        mem_we     = exec_go;
        tail_nxt   = (tail_r == IDX_LAST) ? '0 : tail_r + 1'b1;
        fill_nxt   = fill_r + 1'b1;
        status_nxt = ST_BLOCKED;
      end
    end else begin
      if (fill_r != '0) begin
        woken_nxt  = rd_ext[TID_W-1:0];
        head_nxt   = (head_r == IDX_LAST) ? '0 : head_r + 1'b1;
        fill_nxt   = fill_r - 1'b1;
        status_nxt = ST_WOKEN;
      end else if (count_r == COUNT_MAX) begin
        status_nxt = ST_OVERFLOW;
      end else begin
        count_nxt  = count_r + 1'b1;
        status_nxt = ST_INCR;
      end
    end
    fill_ext              = '0;
    fill_ext[FILL_W-1:0]  = fill_nxt;
    waiting_nxt           = fill_ext[WAITING_W-1:0];
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (exec_go) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Queue memory: one write port at the tail, registered read at the head.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      queue_mem[tail_r] <= mem_wdata;
    end
    rd_data_r <= queue_mem[head_r];
  end

  // Captured request item.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r  <= in_tuser;
      tid_r <= in_tdata[TID_W-1:0];
    end
  end

  // Semaphore state and sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      head_r  <= '0;
      tail_r  <= '0;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        count_r <= cfg_wdata;
        head_r  <= '0;
        tail_r  <= '0;
        fill_r  <= '0;
      end else if (exec_go) begin
        count_r <= count_nxt;
        head_r  <= head_nxt;
        tail_r  <= tail_nxt;
        fill_r  <= fill_nxt;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      out_status_r  <= status_nxt;
      out_woken_r   <= woken_nxt;
      out_count_r   <= count_nxt;
      out_waiting_r <= waiting_nxt;
    end
  end

  `include "counting_semaphore_fifo_assert.svh"

  `CSF_ASSERT_CLK(a_fill_bound, fill_r <= FILL_FULL, "wait queue fill exceeds its depth")
  `CSF_ASSERT_CLK(a_ptr_match, (fill_r == '0 || fill_r == FILL_FULL) |-> head_r == tail_r, "queue pointers disagree with fill")
  `CSF_ASSERT_CLK(a_pop_fill, (exec_go && !cfg_we && status_nxt == ST_WOKEN) |=> fill_r == $past(fill_r) - 1'b1, "wake did not remove a waiter")
  `CSF_ASSERT_CLK(a_accept_exec, in_accept |=> state_r == S_EXEC, "accepted item not executed next")
  `CSF_ASSERT_CLK(a_status_code, out_valid_r |-> out_status_r <= ST_OVERFLOW, "result status out of range")

endmodule

`default_nettype wire

FILE: test/tb_counting_semaphore_fifo.sv
// Self-checking testbench for the counting semaphore with its FIFO wait queue.
`timescale 1ns / 1ps

module tb_counting_semaphore_fifo;
  import csf_pkg::*;

  localparam int WQ_DEPTH     = QUEUE_DEPTH_DEF;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 20;
  localparam int PRINT_LIMIT  = 40;

  typedef enum logic [1:0] {REQ_OP, REQ_LOAD, REQ_HOLD} req_kind_t;

  typedef struct {
    req_kind_t          kind;
    logic               op;
    logic [TID_W-1:0]   tid;
    logic [COUNT_W-1:0] load_value;
  } sem_request_t;

  typedef struct {
    logic [STATUS_W-1:0]  status;
    logic [TID_W-1:0]     woken;
    logic [COUNT_W-1:0]   count;
    logic [WAITING_W-1:0] waiting;
  } sem_reply_t;

  // Block ports; the inputs are driven to known values from time zero.
  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   cfg_we     = 1'b0;
  logic [COUNT_W-1:0]     cfg_wdata  = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // [15:0] thread_id
  logic                   in_tuser   = 1'b0; // [0] op
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // [15:0] woken, [31:16] count, [36:32] waiting
  logic [STATUS_W-1:0]    out_tuser;         // [2:0] status

  // Stimulus and scoreboard state.
  sem_request_t request_q[$];
  sem_reply_t   pending_replies[$];
  int           reqs_accepted = 0;
  int           replies_seen  = 0;
  logic         stim_done     = 1'b0;
  int           error_cnt     = 0;
  int           cycle_cnt     = 0;
  int           send_gap      = 0;
  int           send_run      = 0;
  int           recv_stall    = 0;
  int           recv_run      = 0;

  // Shadow copy of the semaphore state.
  logic [COUNT_W-1:0] sem_cnt = '0;
  logic [TID_W-1:0]   waiters[WQ_DEPTH];
  int                 wq_head = 0;
  int                 wq_tail = 0;
  int                 wq_fill = 0;

  counting_semaphore_fifo uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  task automatic report_mismatch(input string msg);
    if (error_cnt < PRINT_LIMIT) begin
      $display("ERROR cycle %0d: %s", cycle_cnt, msg);
    end
    error_cnt++;
  endtask

  // Idle cycles before the next item; occasional runs of back-to-back items.
  function automatic int idle_draw(inout int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      run_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 9);
  endfunction

  // Loading the initial count also empties the wait queue.
  function automatic void load_count(input logic [COUNT_W-1:0] value);
    sem_cnt = value;
    wq_head = 0;
    wq_tail = 0;
    wq_fill = 0;
  endfunction

  // Applies one wait or signal to the shadow state and returns its reply.
  function automatic sem_reply_t semaphore_step(input logic op, input logic [TID_W-1:0] tid);
    sem_reply_t r;
    r.status = ST_OVERFLOW;
    r.woken  = '0;
    if (op == OP_WAIT) begin
      if (sem_cnt != 0) begin
        sem_cnt  = sem_cnt - 1'b1;
        r.status = ST_GRANTED;
      end else if (wq_fill < WQ_DEPTH) begin
        waiters[wq_tail] = tid;
        wq_tail  = (wq_tail == WQ_DEPTH - 1) ? 0 : wq_tail + 1;
        wq_fill++;
        r.status = ST_BLOCKED;
      end
    end else begin
      if (wq_fill > 0) begin
        r.woken  = waiters[wq_head];
        wq_head  = (wq_head == WQ_DEPTH - 1) ? 0 : wq_head + 1;
        wq_fill--;
        r.status = ST_WOKEN;
      end else if (sem_cnt != COUNT_MAX) begin
        sem_cnt  = sem_cnt + 1'b1;
        r.status = ST_INCR;
      end
    end
    r.count   = sem_cnt;
    r.waiting = WAITING_W'(wq_fill);
    return r;
  endfunction

  task automatic push_op(input logic op, input logic [TID_W-1:0] tid);
    request_q.push_back('{kind: REQ_OP, op: op, tid: tid, load_value: '0});
  endtask

  task automatic push_load(input logic [COUNT_W-1:0] value);
    request_q.push_back('{kind: REQ_LOAD, op: OP_WAIT, tid: '0, load_value: value});
  endtask

  task automatic push_hold();
    request_q.push_back('{kind: REQ_HOLD, op: OP_WAIT, tid: '0, load_value: '0});
  endtask

  // Request driver: presents items, writes the count register and honors
  // pauses only once every outstanding reply has come back.
  always @(posedge clk) begin : req_driver
    sem_request_t head;
    logic         next_valid;
    logic         next_we;
    next_we = 1'b0;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        pending_replies.push_back(semaphore_step(in_tuser, in_tdata));
        reqs_accepted++;
      end
      if (!(in_tvalid && !in_tready)) begin
        next_valid = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (request_q.size() == 0) begin
          stim_done <= 1'b1;
        end else begin
          head = request_q[0];
          case (head.kind)
            REQ_OP: begin
              void'(request_q.pop_front());
              in_tdata   <= head.tid;
              in_tuser   <= head.op;
              next_valid = 1'b1;
              send_gap   = idle_draw(send_run);
            end
            REQ_LOAD: begin
              if (reqs_accepted == replies_seen) begin
                void'(request_q.pop_front());
                cfg_wdata <= head.load_value;
                next_we   = 1'b1;
                load_count(head.load_value);
              end
            end
            default: begin
              if (reqs_accepted == replies_seen) begin
                void'(request_q.pop_front());
              end
            end
          endcase
        end
        in_tvalid <= next_valid;
      end
    end
    cfg_we <= next_we;
  end

  // Reply monitor: checks each accepted reply against the oldest prediction.
  always @(posedge clk) begin : reply_monitor
    sem_reply_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        replies_seen <= replies_seen + 1;
        if (pending_replies.size() == 0) begin
          report_mismatch("reply arrived with no request outstanding");
        end else begin
          want = pending_replies.pop_front();
          if (out_tuser != want.status) begin
            report_mismatch($sformatf("status got %0d want %0d", out_tuser, want.status));
          end
          if (out_tdata[15:0] != want.woken) begin
            report_mismatch($sformatf("woken_thread got %h want %h",
                                      out_tdata[15:0], want.woken));
          end
          if (out_tdata[31:16] != want.count) begin
            report_mismatch($sformatf("current_count got %0d want %0d",
                                      out_tdata[31:16], want.count));
          end
          if (out_tdata[36:32] != want.waiting) begin
            report_mismatch($sformatf("waiting got %0d want %0d",
                                      out_tdata[36:32], want.waiting));
          end
        end
        if (out_tdata[39:37] != '0) begin
          report_mismatch("padding bits of out_tdata are not zero");
        end
        recv_stall = idle_draw(recv_run);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Builds the stimulus, runs it and reports the outcome.
  initial begin : run_test
    int                 n_items;
    int                 wait_pct;
    logic [COUNT_W-1:0] value;
    logic [TID_W-1:0]   tid;

    // Reset state: count zero, so waits block and signals wake in order.
    push_op(OP_WAIT, 16'hFFFF);
    push_op(OP_WAIT, 16'h0000);
    push_op(OP_SIGNAL, 16'h1234);
    push_op(OP_SIGNAL, 16'hFFFF);
    push_op(OP_SIGNAL, 16'h0000);
    push_op(OP_WAIT, 16'h8001);
    // Saturated count: a signal with no waiter overflows.
    push_load(COUNT_MAX);
    push_op(OP_SIGNAL, 16'h00FF);
    push_op(OP_WAIT, 16'hFF00);
    push_op(OP_SIGNAL, 16'h5A5A);
    // Fill the wait queue, then one more blocking wait overflows.
    push_load('0);
    for (int i = 0; i < WQ_DEPTH; i++) begin
      push_op(OP_WAIT, (i % 2) ? (16'hA5A5 ^ TID_W'(i)) : TID_W'(16'h5A5A + i));
    end
    push_op(OP_WAIT, 16'hC3C3);

    // Random phases, each with its own wait/signal mix; each phase after the first loads its own count setting.
    for (int p = 0; p < 12; p++) begin
      if (p > 0) begin
        case (p % 6)
          0:       value = '0;
          1:       value = COUNT_MAX;
          2:       value = COUNT_MAX - COUNT_W'($urandom_range(1, 8));
          3:       value = COUNT_W'($urandom_range(1, 6));
          4:       value = COUNT_W'($urandom);
          default: value = 16'd1;
        endcase
        push_load(value);
      end
      case (p % 3)
        0:       wait_pct = 70;
        1:       wait_pct = 30;
        default: wait_pct = 50;
      endcase
      n_items = $urandom_range(100, 140);
      for (int i = 0; i < n_items; i++) begin
        case ($urandom_range(0, 7))
          0:       tid = '0;
          1:       tid = '1;
          default: tid = TID_W'($urandom);
        endcase
        push_op(($urandom_range(1, 100) <= wait_pct) ? OP_WAIT : OP_SIGNAL, tid);
        if (i == n_items / 2) begin
          push_hold();
        end
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (!(stim_done && reqs_accepted == replies_seen) && cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
    end

    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
    end else begin
      repeat (DRAIN_CYCLES) @(posedge clk);
      if (pending_replies.size() != 0) begin
        report_mismatch($sformatf("%0d replies never arrived", pending_replies.size()));
      end
      if (error_cnt == 0) begin
        $display("DONE: 0 errors");
      end else begin
        $display("DONE: errors detected");
      end
    end
    $finish;
  end

endmodule
